>>> hw/rtl/cro_pkg.sv
// ----------------------------------------------------------------------------
// cro_pkg
// Shared constants, codes and control types of the chunk reorder window.
// ----------------------------------------------------------------------------
package cro_pkg;

	localparam int WINDOW_CHUNKS   = 64;
	localparam int CHUNK_BYTES     = 1024;
	localparam int WORDS_PER_CHUNK = (CHUNK_BYTES + 3) / 4;
	localparam int STORE_WORDS     = WINDOW_CHUNKS * WORDS_PER_CHUNK;

	localparam int SLOT_W  = $clog2(WINDOW_CHUNKS);
	localparam int DPOS_W  = $clog2(WORDS_PER_CHUNK);
	localparam int ADDR_W  = $clog2(STORE_WORDS);
	localparam int ACALC_W = ADDR_W + 2;

	localparam int CHUNK_W  = 22;
	localparam int WOFF_W   = 8;
	localparam int DATA_W   = 32;
	localparam int SIZE_W   = 32;
	localparam int STAT_W   = 3;
	localparam int NBYTE_W  = 3;
	localparam int BYTE_W   = CHUNK_W + 14;
	localparam int WCMP_W   = 16;

	typedef enum logic [STAT_W-1:0] {
		ST_STORED    = 3'd0,
		ST_STALE     = 3'd1,
		ST_BEYOND    = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_WORD_OUT  = 3'd4,
		ST_NOT_READY = 3'd5,
		ST_PAST_END  = 3'd6
	} status_t;

	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_DRAIN   = 1'b1;

	typedef struct packed {
		logic capture;
		logic execute;
		logic cfg_write;
	} cro_cmd_t;

endpackage

>>> hw/rtl/cro_ctrl.sv
// ----------------------------------------------------------------------------
// cro_ctrl
// Sequencer: capture, execute, present result.
// ----------------------------------------------------------------------------
module cro_ctrl import cro_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     cfg_valid,
	output logic     busy,
	output logic     cfg_ready,
	output logic     done,
	output cro_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = start ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign busy          = (state_q == S_EXEC);
	assign cfg_ready     = !busy;
	assign done          = (state_q == S_DONE);
	assign cmd.capture   = start && !busy;
	assign cmd.execute   = (state_q == S_EXEC);
	assign cmd.cfg_write = cfg_valid && cfg_ready;

endmodule

>>> hw/rtl/cro_dpath.sv
// ----------------------------------------------------------------------------
// cro_dpath
// Window state, chunk store and per-item decision logic.
// ----------------------------------------------------------------------------
module cro_dpath import cro_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cro_cmd_t            cmd,
	input  logic                op,
	input  logic [CHUNK_W-1:0]  chunk_number,
	input  logic [WOFF_W-1:0]   word_offset,
	input  logic [DATA_W-1:0]   data_word,
	input  logic                chunk_last_word,
	input  logic [SIZE_W-1:0]   cfg_data,
	output logic [STAT_W-1:0]   status,
	output logic [DATA_W-1:0]   out_word,
	output logic [NBYTE_W-1:0]  out_byte_count,
	output logic                out_chunk_end,
	output logic                file_complete,
	output logic [CHUNK_W-1:0]  base_chunk_out
);

	// captured item
	logic               op_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [WOFF_W-1:0]  woff_q;
	logic [DATA_W-1:0]  data_q;
	logic               last_q;

	// window state
	logic [SIZE_W-1:0]        size_q;
	logic [WINDOW_CHUNKS-1:0] held_q;
	logic [SLOT_W-1:0]        head_q;
	logic [CHUNK_W-1:0]       base_q;
	logic [DPOS_W-1:0]        dpos_q;
	logic [SIZE_W-1:0]        bw_q;

	// result
	status_t             status_q;
	logic [NBYTE_W-1:0]  n_q;
	logic                end_q;
	logic [DATA_W-1:0]   rd_q;

	logic [DATA_W-1:0] mem [STORE_WORDS];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			chunk_q <= chunk_number;
			woff_q  <= word_offset;
			data_q  <= data_word;
			last_q  <= chunk_last_word;
		end
	end

	// receive decision
	logic [CHUNK_W-1:0] chunk_ahead;
	logic [SLOT_W:0]    slot_sum;
	logic [SLOT_W-1:0]  rx_slot;
	logic               rx_stale, rx_beyond, rx_dup, rx_wr;
	logic [ADDR_W-1:0]  wr_idx;

	assign rx_stale    = chunk_q < base_q;
	assign chunk_ahead = chunk_q - base_q;
	assign rx_beyond   = chunk_ahead >= CHUNK_W'(WINDOW_CHUNKS);
	assign slot_sum    = {1'b0, head_q} + {1'b0, chunk_ahead[SLOT_W-1:0]};
	assign rx_slot     = (slot_sum >= (SLOT_W+1)'(WINDOW_CHUNKS))
		? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_CHUNKS)) : slot_sum[SLOT_W-1:0];
	assign rx_dup      = held_q[rx_slot];
	assign rx_wr       = cmd.execute && (op_q == OP_RECEIVE) && !rx_stale && !rx_beyond
		&& !rx_dup && (WCMP_W'(woff_q) < WCMP_W'(WORDS_PER_CHUNK));
	assign wr_idx      = ADDR_W'(rx_slot) * ADDR_W'(WORDS_PER_CHUNK) + ADDR_W'(woff_q);

	// drain decision
	logic [BYTE_W-1:0]  start_b, pos_b, abs_b, size_b, left_b, crem_b, rem_b;
	logic               dr_past, dr_end;
	logic [NBYTE_W-1:0] dr_n;
	logic [ADDR_W-1:0]  rd_idx;
	logic [SIZE_W:0]    bw_sum;

	assign start_b = BYTE_W'(base_q) * BYTE_W'(CHUNK_BYTES);
	assign pos_b   = BYTE_W'(dpos_q) * BYTE_W'(4);
	assign abs_b   = start_b + pos_b;
	assign size_b  = BYTE_W'(size_q);
	assign dr_past = (start_b >= size_b) || (bw_q >= size_q);
	assign left_b  = (size_b > abs_b) ? size_b - abs_b : '0;
	assign crem_b  = BYTE_W'(CHUNK_BYTES) - pos_b;
	assign rem_b   = (left_b < crem_b) ? left_b : crem_b;
	assign dr_n    = (rem_b >= BYTE_W'(4)) ? NBYTE_W'(4) : rem_b[NBYTE_W-1:0];
	assign dr_end  = (pos_b + BYTE_W'(4) >= BYTE_W'(CHUNK_BYTES))
		|| (abs_b + BYTE_W'(4) >= size_b);
	assign rd_idx  = ADDR_W'(head_q) * ADDR_W'(WORDS_PER_CHUNK) + ADDR_W'(dpos_q);
	assign bw_sum  = {1'b0, bw_q} + (SIZE_W+1)'(dr_n);

	status_t stat_d;
	always_comb begin
		if (op_q == OP_DRAIN) begin
			if (!held_q[head_q]) stat_d = ST_NOT_READY;
			else if (dr_past)    stat_d = ST_PAST_END;
			else                 stat_d = ST_WORD_OUT;
		end else begin
			if (rx_stale)        stat_d = ST_STALE;
			else if (rx_beyond)  stat_d = ST_BEYOND;
			else if (rx_dup)     stat_d = ST_DUPLICATE;
			else                 stat_d = ST_STORED;
		end
	end

	// store: one write and one registered read port
	always_ff @(posedge clk) begin
		if (rx_wr) mem[wr_idx] <= data_q;
		if (cmd.execute) rd_q <= mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= stat_d;
			n_q      <= (stat_d == ST_WORD_OUT) ? dr_n : '0;
			end_q    <= (stat_d == ST_WORD_OUT) && dr_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			held_q <= '0;
			head_q <= '0;
			base_q <= '0;
			dpos_q <= '0;
			bw_q   <= '0;
		end else begin
			if (cmd.cfg_write) size_q <= cfg_data;
			if (cmd.execute) begin
				if (stat_d == ST_STORED && last_q) held_q[rx_slot] <= 1'b1;
				if (stat_d == ST_WORD_OUT) begin
					bw_q <= bw_sum[SIZE_W] ? '1 : bw_sum[SIZE_W-1:0];
					if (dr_end) begin
						held_q[head_q] <= 1'b0;
						head_q <= (head_q == SLOT_W'(WINDOW_CHUNKS - 1)) ? '0 : head_q + 1'b1;
						base_q <= base_q + 1'b1;
						dpos_q <= '0;
					end else begin
						dpos_q <= dpos_q + 1'b1;
					end
				end
			end
		end
	end

	// zero the bytes past the valid count
	always_comb begin
		case (n_q)
			3'd0:    out_word = '0;
			3'd1:    out_word = {24'd0, rd_q[7:0]};
			3'd2:    out_word = {16'd0, rd_q[15:0]};
			3'd3:    out_word = {8'd0, rd_q[23:0]};
			default: out_word = rd_q;
		endcase
	end

	assign status         = status_q;
	assign out_byte_count = n_q;
	assign out_chunk_end  = end_q;
	assign file_complete  = bw_q >= size_q;
	assign base_chunk_out = base_q;

endmodule

>>> hw/rtl/chunk_reorder_window_unit.sv
// ----------------------------------------------------------------------------
// chunk_reorder_window_unit
// Receive-side reorder window: stores out-of-order chunk words in a ring of
// slots and drains the base chunk in order, cut to the file size.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  ------------------------------------
//  command   start / busy              op, chunk_number, word_offset,
//                                      data_word, chunk_last_word
//  config    cfg_valid / cfg_ready     cfg_data (file size in bytes)
//  result    done (one-cycle strobe)   status, out_word, out_byte_count,
//                                      out_chunk_end, file_complete,
//                                      base_chunk_out
//
// Each item has an execute cycle (decision, store write or store read, state
// update), then the result cycle, in which the next item may already be taken.
// Busy is high only in the execute cycle; the store access in that cycle sets
// the rate.
// Reset clears the held marks, base chunk, ring head, drain position, byte
// total and file size; the store itself is not cleared.
// The receiver cannot stall: the result is shown for the one done cycle.
// ----------------------------------------------------------------------------
module chunk_reorder_window_unit import cro_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                op,
	input  logic [CHUNK_W-1:0]  chunk_number,
	input  logic [WOFF_W-1:0]   word_offset,
	input  logic [DATA_W-1:0]   data_word,
	input  logic                chunk_last_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SIZE_W-1:0]   cfg_data,
	output logic                done,
	output logic [STAT_W-1:0]   status,
	output logic [DATA_W-1:0]   out_word,
	output logic [NBYTE_W-1:0]  out_byte_count,
	output logic                out_chunk_end,
	output logic                file_complete,
	output logic [CHUNK_W-1:0]  base_chunk_out
);

	cro_cmd_t cmd;

	// sequencer: capture on start, then the execute state and the result state
	cro_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done),
		.cmd       (cmd)
	);

	// window state, chunk store and result registers
	cro_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.op              (op),
		.chunk_number    (chunk_number),
		.word_offset     (word_offset),
		.data_word       (data_word),
		.chunk_last_word (chunk_last_word),
		.cfg_data        (cfg_data),
		.status          (status),
		.out_word        (out_word),
		.out_byte_count  (out_byte_count),
		.out_chunk_end   (out_chunk_end),
		.file_complete   (file_complete),
		.base_chunk_out  (base_chunk_out)
	);

endmodule

>>> verif/chunk_reorder_window_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reorder_window_unit_tb
// Self-checking bench for the chunk reorder window. It drives receive and
// drain items through the start/busy port, rewrites the file size between
// phases and predicts every result strobe from its own copy of the window
// state.
// ----------------------------------------------------------------------------
module chunk_reorder_window_unit_tb import cro_pkg::*; ();

	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT  = 200000;
	// words a slot should hold before the bench likes to close its chunk;
	// covers the longest final chunk of the base-relative random sizes (64 bytes)
	localparam int PREP_WORDS   = 16;
	localparam int CHUNK_MAX    = (1 << CHUNK_W) - 1;

	typedef struct packed {
		logic               op;
		logic [CHUNK_W-1:0] chunk;
		logic [WOFF_W-1:0]  woff;
		logic [DATA_W-1:0]  data;
		logic               last;
	} item_t;

	typedef struct {
		status_t             status;
		logic [DATA_W-1:0]   word;
		logic [NBYTE_W-1:0]  nbytes;
		logic                chunk_end;
		logic                complete;
		logic [CHUNK_W-1:0]  base;
	} result_t;

	// ------------------------------------------------------------------------
	// Window predictor plus the queue of results still to come.
	// ------------------------------------------------------------------------
	class reorder_scoreboard;
		bit                 slot_held  [WINDOW_CHUNKS];
		logic [DATA_W-1:0]  word_mem   [STORE_WORDS];
		bit                 word_valid [STORE_WORDS];
		logic [CHUNK_W-1:0] base_no;
		int                 head_slot;
		int                 drain_pos;
		logic [SIZE_W-1:0]  bytes_out;
		logic [SIZE_W-1:0]  size_bytes;
		result_t            expected_results [$];
		int                 mismatches;

		function new();
			base_no    = '0;
			head_slot  = 0;
			drain_pos  = 0;
			bytes_out  = '0;
			size_bytes = '0;
			mismatches = 0;
			foreach (slot_held[i]) slot_held[i] = 1'b0;
			foreach (word_valid[i]) word_valid[i] = 1'b0;
		endfunction

		function int slot_of(int ahead);
			return (head_slot + ahead) % WINDOW_CHUNKS;
		endfunction

		// words a drain of this chunk will read under the given size
		function int needed_words(longint unsigned chunk, longint unsigned sz);
			longint unsigned chunk_start, len;
			chunk_start = chunk * CHUNK_BYTES;
			if (chunk_start >= sz)
				return 0;
			len = sz - chunk_start;
			if (len > CHUNK_BYTES)
				len = CHUNK_BYTES;
			return int'((len + 3) / 4);
		endfunction

		// closing this chunk now would leave no unwritten word for a drain
		function bit chunk_ready(int slot, logic [CHUNK_W-1:0] chunk, int woff);
			int need;
			need = needed_words(chunk, size_bytes);
			for (int w = 0; w < need; w++)
				if (!word_valid[slot * WORDS_PER_CHUNK + w] && w != woff)
					return 1'b0;
			return 1'b1;
		endfunction

		// a new size must not make any held chunk drain an unwritten word
		function bit size_is_safe(logic [SIZE_W-1:0] sz);
			int slot, need;
			for (int a = 0; a < WINDOW_CHUNKS; a++) begin
				slot = slot_of(a);
				if (slot_held[slot]) begin
					need = needed_words(longint'(base_no) + a, sz);
					// head chunk mid-drain still reads the word at the drain position
					if (a == 0 && need > 0 && drain_pos >= need)
						need = drain_pos + 1;
					for (int w = 0; w < need && w < WORDS_PER_CHUNK; w++)
						if (!word_valid[slot * WORDS_PER_CHUNK + w])
							return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function status_t receive(item_t it);
			logic [CHUNK_W-1:0] ahead;
			int slot;
			if (it.chunk < base_no)
				return ST_STALE;
			ahead = it.chunk - base_no;
			if (ahead >= WINDOW_CHUNKS)
				return ST_BEYOND;
			slot = slot_of(int'(ahead));
			if (slot_held[slot])
				return ST_DUPLICATE;
			if (it.woff < WORDS_PER_CHUNK) begin
				word_mem[slot * WORDS_PER_CHUNK + it.woff]   = it.data;
				word_valid[slot * WORDS_PER_CHUNK + it.woff] = 1'b1;
			end
			if (it.last)
				slot_held[slot] = 1'b1;
			return ST_STORED;
		endfunction

		function status_t drain(inout result_t r);
			longint unsigned chunk_start, len, pos, rem;
			int n;
			logic [DATA_W-1:0] w;
			if (!slot_held[head_slot])
				return ST_NOT_READY;
			chunk_start = longint'(base_no) * CHUNK_BYTES;
			if (chunk_start >= size_bytes || bytes_out >= size_bytes)
				return ST_PAST_END;
			len = size_bytes - chunk_start;
			if (len > CHUNK_BYTES)
				len = CHUNK_BYTES;
			pos = drain_pos * 4;
			rem = (len > pos) ? len - pos : 0;
			n   = (rem >= 4) ? 4 : int'(rem);
			w   = (drain_pos < WORDS_PER_CHUNK) ?
				word_mem[head_slot * WORDS_PER_CHUNK + drain_pos] : '0;
			if (n < 4)
				w &= (32'h1 << (8 * n)) - 32'h1;
			// byte total saturates
			if (32'hFFFF_FFFF - bytes_out < SIZE_W'(n))
				bytes_out = '1;
			else
				bytes_out = bytes_out + SIZE_W'(n);
			r.word   = w;
			r.nbytes = NBYTE_W'(n);
			if (pos + 4 >= len) begin
				r.chunk_end = 1'b1;
				slot_held[head_slot] = 1'b0;
				head_slot = (head_slot + 1) % WINDOW_CHUNKS;
				base_no   = base_no + 1'b1;
				drain_pos = 0;
			end else begin
				drain_pos = (drain_pos + 1) & 8'hFF;
			end
			return ST_WORD_OUT;
		endfunction

		function void note_item(item_t it);
			result_t r;
			r.word      = '0;
			r.nbytes    = '0;
			r.chunk_end = 1'b0;
			if (it.op == OP_DRAIN)
				r.status = drain(r);
			else
				r.status = receive(it);
			r.complete = (bytes_out >= size_bytes);
			r.base     = base_no;
			expected_results.push_back(r);
		endfunction

		function void compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
				mismatches++;
			end
		endfunction

		function void check_result(logic [STAT_W-1:0] st, logic [DATA_W-1:0] w,
				logic [NBYTE_W-1:0] nb, logic ce, logic fc, logic [CHUNK_W-1:0] b);
			result_t e;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual status %0h",
					$time, st);
				mismatches++;
				return;
			end
			e = expected_results.pop_front();
			compare("status", e.status, st);
			compare("out_word", e.word, w);
			compare("out_byte_count", e.nbytes, nb);
			compare("out_chunk_end", e.chunk_end, ce);
			compare("file_complete", e.complete, fc);
			compare("base_chunk_out", e.base, b);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               op;
	logic [CHUNK_W-1:0] chunk_number;
	logic [WOFF_W-1:0]  word_offset;
	logic [DATA_W-1:0]  data_word;
	logic               chunk_last_word;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [SIZE_W-1:0]  cfg_data;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [DATA_W-1:0]  out_word;
	logic [NBYTE_W-1:0] out_byte_count;
	logic               out_chunk_end;
	logic               file_complete;
	logic [CHUNK_W-1:0] base_chunk_out;

	reorder_scoreboard window_check = new();
	int cycle_count;

	chunk_reorder_window_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.chunk_number   (chunk_number),
		.word_offset    (word_offset),
		.data_word      (data_word),
		.chunk_last_word(chunk_last_word),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.status         (status),
		.out_word       (out_word),
		.out_byte_count (out_byte_count),
		.out_chunk_end  (out_chunk_end),
		.file_complete  (file_complete),
		.base_chunk_out (base_chunk_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Results cannot be held off: every done cycle is checked at the edge
	// that ends it.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			window_check.check_result(status, out_word, out_byte_count, out_chunk_end,
				file_complete, base_chunk_out);
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic item_t make_receive(int chunk, int woff, logic [DATA_W-1:0] data,
			logic last);
		item_t it;
		it.op    = OP_RECEIVE;
		it.chunk = CHUNK_W'(chunk);
		it.woff  = WOFF_W'(woff);
		it.data  = data;
		it.last  = last;
		return it;
	endfunction

	function automatic item_t make_drain();
		item_t it;
		it.op    = OP_DRAIN;
		it.chunk = CHUNK_W'($urandom);
		it.woff  = WOFF_W'($urandom);
		it.data  = $urandom;
		it.last  = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Mostly in-order chunk traffic near the base, plus drains and noise
	// (stale, beyond the window, fully random numbers, duplicates).
	function automatic item_t random_item();
		item_t it;
		int r, ahead, slot, gap_word;
		if ($urandom_range(0, 99) < 30)
			return make_drain();
		it = make_receive(0, $urandom_range(0, 255), $urandom, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 99) < 70) begin
			r = $urandom_range(0, 9);
			ahead = (r < 5) ? 0 : (r < 8) ? $urandom_range(1, 2) :
				$urandom_range(0, WINDOW_CHUNKS - 1);
			it.chunk = CHUNK_W'(window_check.base_no + ahead);
			slot = window_check.slot_of(ahead);
			// fill the leading words of the slot first
			gap_word = -1;
			for (int k = 0; k < PREP_WORDS; k++)
				if (gap_word < 0 && !window_check.word_valid[slot * WORDS_PER_CHUNK + k])
					gap_word = k;
			if (gap_word >= 0)
				it.woff = WOFF_W'(gap_word);
			it.last = (gap_word < 0) ? ($urandom_range(0, 2) != 0) :
				($urandom_range(0, 9) == 0);
		end else begin
			case ($urandom_range(0, 3))
				0: it.chunk = (window_check.base_no == 0) ? CHUNK_W'($urandom) :
					CHUNK_W'($urandom_range(0, window_check.base_no - 1));
				1: it.chunk = CHUNK_W'($urandom_range(window_check.base_no + WINDOW_CHUNKS,
					CHUNK_MAX));
				2: it.chunk = CHUNK_W'($urandom);
				default: it.chunk = CHUNK_W'(window_check.base_no +
					$urandom_range(0, WINDOW_CHUNKS - 1));
			endcase
		end
		return it;
	endfunction

	// Drives one item and waits for it to be taken (start high, busy low).
	task automatic drive_item(input item_t cmd, input bit allow_gap);
		int gap, slot;
		gap = (allow_gap && $urandom_range(0, 99) < 35) ? $urandom_range(1, 5) : 0;
		// never close a chunk whose drain would read a never-written word
		if (cmd.op == OP_RECEIVE && cmd.last && cmd.chunk >= window_check.base_no &&
				cmd.chunk - window_check.base_no < WINDOW_CHUNKS) begin
			slot = window_check.slot_of(int'(cmd.chunk - window_check.base_no));
			if (!window_check.slot_held[slot] &&
					!window_check.chunk_ready(slot, cmd.chunk, cmd.woff))
				cmd.last = 1'b0;
		end
		@(negedge clk);
		repeat (gap) begin
			start = 1'b0;
			@(negedge clk);
		end
		start           = 1'b1;
		op              = cmd.op;
		chunk_number    = cmd.chunk;
		word_offset     = cmd.woff;
		data_word       = cmd.data;
		chunk_last_word = cmd.last;
		do @(posedge clk); while (busy !== 1'b0);
		window_check.note_item(cmd);
	endtask

	// Lets every result drain, then writes the file size.
	task automatic write_file_size(input logic [SIZE_W-1:0] sz);
		@(negedge clk);
		start = 1'b0;
		while (window_check.expected_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = sz;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		window_check.size_bytes = sz;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int sent, phase_len;
		logic [SIZE_W-1:0] sz;

		arst_n          = 1'b0;
		start           = 1'b0;
		op              = OP_RECEIVE;
		chunk_number    = '0;
		word_offset     = '0;
		data_word       = '0;
		chunk_last_word = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed part, file size still zero after reset ----
		drive_item(make_drain(), 1'b1);                           // nothing held, complete
		drive_item(make_receive(WINDOW_CHUNKS, 0, '0, 1'b0), 1'b1);  // first chunk beyond
		drive_item(make_receive(CHUNK_MAX, 255, '1, 1'b1), 1'b1);    // top chunk number
		drive_item(make_receive(0, 0, 32'hFFFF_FFFF, 1'b0), 1'b1);
		drive_item(make_receive(0, 1, 32'h0000_0000, 1'b0), 1'b1);
		drive_item(make_receive(0, 2, 32'hA5A5_A5A5, 1'b0), 1'b1);
		drive_item(make_receive(0, 3, 32'h5A5A_5A5A, 1'b1), 1'b1);   // chunk 0 held
		drive_item(make_receive(0, 4, $urandom, 1'b1), 1'b1);        // duplicate
		drive_item(make_drain(), 1'b1);                              // start at size: past end
		drive_item(make_receive(WINDOW_CHUNKS - 1, 255, $urandom, 1'b0), 1'b1); // window edge

		// 13-byte file: three full words and one cut word
		write_file_size(32'd13);
		drive_item(make_drain(), 1'b1);
		drive_item(make_drain(), 1'b1);
		// shrink below the bytes already out: past end inside the chunk
		write_file_size(32'd6);
		drive_item(make_drain(), 1'b1);
		write_file_size(32'd13);
		drive_item(make_drain(), 1'b1);
		drive_item(make_drain(), 1'b1);                              // cut word, chunk end
		drive_item(make_drain(), 1'b1);                              // next chunk not held
		drive_item(make_receive(0, 7, $urandom, 1'b1), 1'b1);        // stale now

		write_file_size(32'hFFFF_FFFF);
		drive_item(make_receive(1, 0, $urandom, 1'b0), 1'b1);
		drive_item(make_drain(), 1'b1);

		// ---- random phases, each behind a fresh file size ----
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// the back-to-back stretch keeps its size so nothing pauses it
			if (sent <= 150 || sent >= 250) begin
				case ($urandom_range(0, 9))
					0: sz = '0;
					1: sz = '1;
					2: sz = $urandom_range(0, window_check.bytes_out);
					3: sz = $urandom;
					default: sz = window_check.base_no * CHUNK_BYTES + $urandom_range(1, 64);
				endcase
				// a size at the base chunk start makes every held chunk past end
				if (!window_check.size_is_safe(sz))
					sz = window_check.base_no * CHUNK_BYTES;
				write_file_size(sz);
			end
			phase_len = $urandom_range(10, 40);
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				// one long back-to-back stretch in the middle
				drive_item(random_item(), !(sent >= 150 && sent < 250));
				sent++;
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (window_check.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (window_check.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/cro_pkg.sv
hw/rtl/cro_ctrl.sv
hw/rtl/cro_dpath.sv
hw/rtl/chunk_reorder_window_unit.sv
verif/chunk_reorder_window_unit_tb.sv
